// ----- rtl/core/lat_pkg.sv -----
// Shared types and codes for the link address table.
// No dependencies; lat_ctrl, link_address_table and the testbench import this package.
package lat_pkg;

   // Field widths fixed by the request and response words
   localparam int MAC_W    = 48;
   localparam int IP_W     = 32;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int DEFAULT_TABLE_DEPTH = 16;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_SET_IP = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [MAC_W-1:0]    link_mac;
      logic                mesh_in;
      logic [IP_W-1:0]     ip_in;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                mesh_out;
      logic                route_drop;
      logic [IP_W-1:0]     route_ip;
      logic [COUNT_W-1:0]  link_count;
      logic                last;
   } rsp_word_type;

endpackage

// ----- rtl/core/lat_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents when both ports hit the same address.
module lat_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/lat_ctrl.sv -----
// Table sequencer: scans the entry RAM, keeps valid bits and the live count,
// and builds one response word at a time. Depends on lat_pkg.
module lat_ctrl import lat_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
   parameter int ENTRY_W     = IDX_W + 1 + IP_W + MAC_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_word_type       req_data,
   output logic               res_valid,
   output rsp_word_type       res_data,
   input  logic               res_take,
   output logic               ram_we,
   output logic [IDX_W-1:0]   ram_waddr,
   output logic [ENTRY_W-1:0] ram_wdata,
   output logic [IDX_W-1:0]   ram_raddr,
   input  logic [ENTRY_W-1:0] ram_rdata
);

   localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
   localparam int RANK_W   = IDX_W;
   localparam int IP_LSB   = MAC_W;
   localparam int MESH_BIT = MAC_W + IP_W;
   localparam int RANK_LSB = MAC_W + IP_W + 1;

   typedef enum logic [2:0] {S_IDLE, S_ADD, S_FIND, S_UPDATE, S_SHIFT, S_EMIT} state_type;

   state_type              state_ff, state_in;
   req_word_type           req_ff, req_in;
   logic                   rd_busy_ff, rd_busy_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   proc_valid_ff, proc_valid_in;
   logic [IDX_W-1:0]       proc_idx_ff, proc_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   found_ff, found_in;
   logic                   placed_ff, placed_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [RANK_W-1:0]      best_rank_ff, best_rank_in;
   logic [IP_W-1:0]        best_ip_ff, best_ip_in;
   logic                   best_mesh_ff, best_mesh_in;
   logic [MAC_W-1:0]       best_key_ff, best_key_in;
   logic [RANK_W-1:0]      pick_rank_ff, pick_rank_in;
   rsp_word_type           res_ff, res_in;

   logic [MAC_W-1:0]  e_key;
   logic [IP_W-1:0]   e_ip;
   logic              e_mesh;
   logic [RANK_W-1:0] e_rank;
   logic              e_live;
   logic              e_match;
   logic              last_read;
   logic              last_proc;
   logic [CNT_W-1:0]  count_dec;

   // Decode the word returned for the entry under processing
   assign e_key     = ram_rdata[MAC_W-1:0];
   assign e_ip      = ram_rdata[IP_LSB +: IP_W];
   assign e_mesh    = ram_rdata[MESH_BIT];
   assign e_rank    = ram_rdata[RANK_LSB +: RANK_W];
   assign e_live    = valid_ff[proc_idx_ff];
   assign last_read = (rd_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign last_proc = proc_valid_ff && (proc_idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign count_dec = count_ff - CNT_W'(1);

   // Clear walks by age; keyed lookups keep the newest key match
   assign e_match = (req_ff.opcode == OP_CLEAR) ? (e_rank == pick_rank_ff) :
                    ((e_key == req_ff.link_mac) && (!found_ff || (e_rank < best_rank_ff)));

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res_data  = res_ff;
   assign ram_raddr = rd_idx_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_busy_in    = rd_busy_ff;
      rd_idx_in     = rd_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      found_in      = found_ff;
      placed_in     = placed_ff;
      best_idx_in   = best_idx_ff;
      best_rank_in  = best_rank_ff;
      best_ip_in    = best_ip_ff;
      best_mesh_in  = best_mesh_ff;
      best_key_in   = best_key_ff;
      pick_rank_in  = pick_rank_ff;
      res_in        = res_ff;
      ram_we        = 1'b0;
      ram_waddr     = proc_idx_ff;
      ram_wdata     = ram_rdata;

      // Advance the read pointer; its data arrives in the next cycle
      proc_valid_in = rd_busy_ff;
      proc_idx_in   = rd_idx_ff;
      if (rd_busy_ff) begin
         if (last_read) begin
            rd_busy_in = 1'b0;
            rd_idx_in  = '0;
         end else begin
            rd_idx_in = rd_idx_ff + IDX_W'(1);
         end
      end

      case (state_ff)
         S_IDLE: begin
            res_in.status     = ST_OK;
            res_in.mesh_out   = 1'b0;
            res_in.route_drop = 1'b0;
            res_in.route_ip   = '0;
            res_in.link_count = COUNT_W'(count_ff);
            res_in.last       = 1'b1;
            if (req_valid) begin
               req_in       = req_data;
               found_in     = 1'b0;
               placed_in    = 1'b0;
               pick_rank_in = '0;
               case (req_data.opcode)
                  OP_ADD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        res_in.status = ST_FULL;
                        state_in      = S_EMIT;
                     end else begin
                        rd_busy_in = 1'b1;
                        rd_idx_in  = '0;
                        state_in   = S_ADD;
                     end
                  end
                  OP_REMOVE, OP_SET_IP, OP_QUERY: begin
                     rd_busy_in = 1'b1;
                     rd_idx_in  = '0;
                     state_in   = S_FIND;
                  end
                  OP_CLEAR: begin
                     if (count_ff == '0) begin
                        state_in = S_EMIT;
                     end else begin
                        rd_busy_in = 1'b1;
                        rd_idx_in  = '0;
                        state_in   = S_FIND;
                     end
                  end
                  default: begin
                     state_in = S_EMIT;
                  end
               endcase
            end
         end

         S_ADD: begin
            // Age every live entry; drop the new one into the first free slot
            if (proc_valid_ff) begin
               if (e_live) begin
                  ram_we    = 1'b1;
                  ram_wdata = {e_rank + RANK_W'(1), e_mesh, e_ip, e_key};
               end else if (!placed_ff) begin
                  ram_we                = 1'b1;
                  ram_wdata             = {RANK_W'(0), req_ff.mesh_in, IP_W'(0),
                                           req_ff.link_mac};
                  valid_in[proc_idx_ff] = 1'b1;
                  placed_in             = 1'b1;
               end
            end
            if (last_proc) begin
               count_in          = count_ff + CNT_W'(1);
               res_in.link_count = COUNT_W'(count_ff + CNT_W'(1));
               state_in          = S_EMIT;
            end
         end

         S_FIND: begin
            // Track the entry that matches
            if (proc_valid_ff && e_live && e_match) begin
               found_in     = 1'b1;
               best_idx_in  = proc_idx_ff;
               best_rank_in = e_rank;
               best_ip_in   = e_ip;
               best_mesh_in = e_mesh;
               best_key_in  = e_key;
            end
            if (last_proc) begin
               state_in = S_UPDATE;
            end
         end

         S_UPDATE: begin
            res_in.status     = ST_OK;
            res_in.mesh_out   = 1'b0;
            res_in.route_drop = 1'b0;
            res_in.route_ip   = '0;
            res_in.link_count = COUNT_W'(count_ff);
            res_in.last       = 1'b1;
            state_in          = S_EMIT;
            if (!found_ff) begin
               res_in.status = ST_NOT_FOUND;
            end else begin
               case (req_ff.opcode)
                  OP_QUERY: begin
                     res_in.mesh_out = best_mesh_ff;
                  end
                  OP_SET_IP: begin
                     ram_we    = 1'b1;
                     ram_waddr = best_idx_ff;
                     ram_wdata = {best_rank_ff, best_mesh_ff, req_ff.ip_in, best_key_ff};
                  end
                  OP_REMOVE: begin
                     valid_in[best_idx_ff] = 1'b0;
                     count_in              = count_dec;
                     res_in.route_drop     = (best_ip_ff != '0);
                     res_in.route_ip       = best_ip_ff;
                     res_in.link_count     = COUNT_W'(count_dec);
                     rd_busy_in            = 1'b1;
                     rd_idx_in             = '0;
                     state_in              = S_SHIFT;
                  end
                  OP_CLEAR: begin
                     valid_in[best_idx_ff] = 1'b0;
                     count_in              = count_dec;
                     res_in.route_drop     = (best_ip_ff != '0);
                     res_in.route_ip       = best_ip_ff;
                     res_in.link_count     = COUNT_W'(count_dec);
                     res_in.last           = (count_dec == '0);
                  end
                  default: begin
                     res_in.status = ST_OK;
                  end
               endcase
            end
         end

         S_SHIFT: begin
            // Close the age gap left by the removed entry
            if (proc_valid_ff && e_live && (e_rank > best_rank_ff)) begin
               ram_we    = 1'b1;
               ram_wdata = {e_rank - RANK_W'(1), e_mesh, e_ip, e_key};
            end
            if (last_proc) begin
               state_in = S_EMIT;
            end
         end

         S_EMIT: begin
            // Hand the word over; clear goes on with the next oldest entry
            if (res_take) begin
               if ((req_ff.opcode == OP_CLEAR) && !res_ff.last) begin
                  pick_rank_in = pick_rank_ff + RANK_W'(1);
                  found_in     = 1'b0;
                  rd_busy_in   = 1'b1;
                  rd_idx_in    = '0;
                  state_in     = S_FIND;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_busy_ff    <= 1'b0;
         rd_idx_ff     <= '0;
         proc_valid_ff <= 1'b0;
         valid_ff      <= '0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rd_busy_ff    <= rd_busy_in;
         rd_idx_ff     <= rd_idx_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
      end
      req_ff       <= req_in;
      proc_idx_ff  <= proc_idx_in;
      found_ff     <= found_in;
      placed_ff    <= placed_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_ip_ff   <= best_ip_in;
      best_mesh_ff <= best_mesh_in;
      best_key_ff  <= best_key_in;
      pick_rank_ff <= pick_rank_in;
      res_ff       <= res_in;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("live count above table depth");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(valid_ff) == count_ff))
      else $error("live count disagrees with valid bits");

   a_single_word_last: assert property (@(posedge clock) disable iff (reset)
      (res_valid && (req_ff.opcode != OP_CLEAR)) |-> res_data.last)
      else $error("non-clear operation gave a word without last");

   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && rd_busy_ff) |-> (ram_waddr != ram_raddr))
      else $error("write and read hit the same entry in one cycle");
`endif

endmodule

// ----- rtl/core/link_address_table.sv -----
// Link address table: MAC-keyed link table with mesh flag and IP per entry.
// Depends on lat_pkg, lat_ram and lat_ctrl.
//
// Usage:
//   req_*  : valid/ready channel carrying one request word (opcode, link_mac,
//            mesh_in, ip_in). A word is taken only while the sequencer is idle.
//   rsp_*  : valid/ready channel carrying response words. Every operation
//            but clear gives one word with last set; clear gives one word per live
//            entry, newest first, last set on the final one (a single word
//            when the table is empty).
//   An entry RAM scan reads one entry per cycle over the RAM read port. Add
//   is one scan; query and set IP are a match scan and an update step; remove
//   is a match scan, an update step and an age-fixup scan; clear is a match
//   scan and an update step per entry. Add to a full table, clear of an empty
//   table and unused opcodes go straight to the output step. The sequencer
//   takes the next request once the last word of the previous one is taken.
//   Reset empties the table at once (valid bits and count are flip-flops);
//   there is no clearing pass. A stalled rsp_ready holds the output word;
//   the sequencer parks until the output register frees, and can take a new
//   request while the previous word is still waiting.
module link_address_table import lat_pkg::*; #(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENTRY_W = IDX_W + 1 + IP_W + MAC_W;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [ENTRY_W-1:0] ram_rdata;
   logic               res_valid;
   rsp_word_type       res_data;
   logic               res_take;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_data_ff;

   lat_ram #(
      .WIDTH  (ENTRY_W),
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_entry_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   lat_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .ENTRY_W     (ENTRY_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_take  (res_take),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // Load the output register when it is empty or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/link_address_table_tb.sv -----
// Self-checking testbench for link_address_table: directed and random table operations.
// Depends on lat_pkg and the link_address_table RTL; holds its own table predictor.
module link_address_table_tb;
   import lat_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS      = DEFAULT_TABLE_DEPTH;
   localparam int CLK_HALF         = 10;
   localparam int RESET_CYCLES     = 4;
   localparam int RANDOM_ITEMS     = 290;
   localparam int CALM_ITEMS       = 60;
   localparam int SEGMENT_ITEMS    = 40;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int LONG_HOLD_ITEM   = 100;
   localparam int DRAIN_CYCLES     = 4 * TABLE_SLOTS + 20;
   localparam int MAX_PRINTED      = 50;
   localparam longint RUN_LIMIT_NS = 64'd20_000_000;

   // Opcodes the block treats as no-ops
   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam logic [MAC_W-1:0] MAC_ZERO = '0;
   localparam logic [MAC_W-1:0] MAC_ONES = '1;
   localparam logic [IP_W-1:0]  IP_ONES  = '1;

   // Table predictor and store of pending response words
   class link_table_scoreboard;
      logic [MAC_W-1:0] slot_mac  [TABLE_SLOTS];
      logic [IP_W-1:0]  slot_ip   [TABLE_SLOTS];
      logic             slot_mesh [TABLE_SLOTS];
      bit               slot_live [TABLE_SLOTS];
      int unsigned      slot_age  [TABLE_SLOTS];
      int unsigned      live_links;
      rsp_word_type     due_rsp[$];
      int               errors;
      int               rsp_seen;

      function new();
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         live_links = 0;
         errors = 0;
         rsp_seen = 0;
      endfunction

      function int pending_count();
         return due_rsp.size();
      endfunction

      // Newest live entry with this key, or -1
      function int newest_match(logic [MAC_W-1:0] mac);
         int best;
         best = -1;
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && slot_mac[i] == mac &&
                (best < 0 || slot_age[i] < slot_age[best]))
               best = i;
         return best;
      endfunction

      // Newest live entry of all, or -1 when empty
      function int newest_slot();
         int found;
         found = -1;
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (found < 0 && slot_live[i] && slot_age[i] == 0) found = i;
         return found;
      endfunction

      // Drop an entry and close the gap in the age order
      function void retire(int s);
         int unsigned r;
         r = slot_age[s];
         slot_live[s] = 1'b0;
         for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_live[i] && slot_age[i] > r) slot_age[i]--;
         if (live_links > 0) live_links--;
      endfunction

      function void queue_rsp(logic [STATUS_W-1:0] status, logic mesh, logic drop,
                              logic [IP_W-1:0] ip, logic last);
         rsp_word_type w;
         w.status     = status;
         w.mesh_out   = mesh;
         w.route_drop = drop;
         w.route_ip   = ip;
         w.link_count = COUNT_W'(live_links);
         w.last       = last;
         due_rsp.push_back(w);
      endfunction

      // Apply one accepted request word and queue the words it must produce
      function void note_request(req_word_type w);
         int s;
         logic [IP_W-1:0] old_ip;
         case (w.opcode)
            OP_ADD: begin
               s = -1;
               for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                  if (!slot_live[i]) s = i;
               if (live_links >= TABLE_SLOTS || s < 0) begin
                  queue_rsp(ST_FULL, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < TABLE_SLOTS; i++)
                     if (slot_live[i]) slot_age[i]++;
                  slot_mac[s]  = w.link_mac;
                  slot_ip[s]   = '0;
                  slot_mesh[s] = w.mesh_in;
                  slot_age[s]  = 0;
                  slot_live[s] = 1'b1;
                  live_links++;
                  queue_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1);
               end
            end
            OP_REMOVE: begin
               s = newest_match(w.link_mac);
               if (s < 0) begin
                  queue_rsp(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  old_ip = slot_ip[s];
                  retire(s);
                  queue_rsp(ST_OK, 1'b0, old_ip != '0, old_ip, 1'b1);
               end
            end
            OP_SET_IP: begin
               s = newest_match(w.link_mac);
               if (s < 0) begin
                  queue_rsp(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  slot_ip[s] = w.ip_in;
                  queue_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1);
               end
            end
            OP_QUERY: begin
               s = newest_match(w.link_mac);
               if (s < 0) queue_rsp(ST_NOT_FOUND, 1'b0, 1'b0, '0, 1'b1);
               else queue_rsp(ST_OK, slot_mesh[s], 1'b0, '0, 1'b1);
            end
            OP_CLEAR: begin
               // empty table still answers with one word
               if (live_links == 0) begin
                  queue_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1);
               end else begin
                  s = newest_slot();
                  while (s >= 0) begin
                     old_ip = slot_ip[s];
                     retire(s);
                     queue_rsp(ST_OK, 1'b0, old_ip != '0, old_ip, live_links == 0);
                     s = newest_slot();
                  end
               end
            end
            default: queue_rsp(ST_OK, 1'b0, 1'b0, '0, 1'b1);
         endcase
      endfunction

      task report_mismatch(string what, logic [IP_W-1:0] got, logic [IP_W-1:0] want);
         if (errors < MAX_PRINTED)
            $display("ERROR t=%0t rsp %0d %s: got 0x%0h want 0x%0h",
                     $time, rsp_seen, what, got, want);
         errors++;
      endtask

      // Compare one accepted response word with the oldest pending one
      task check_response(rsp_word_type got);
         rsp_word_type want;
         if (due_rsp.size() == 0) begin
            report_mismatch("word with none pending, link_count", got.link_count, '0);
         end else begin
            want = due_rsp.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", got.status, want.status);
            if (got.mesh_out !== want.mesh_out)
               report_mismatch("mesh_out", got.mesh_out, want.mesh_out);
            if (got.route_drop !== want.route_drop)
               report_mismatch("route_drop", got.route_drop, want.route_drop);
            if (got.route_ip !== want.route_ip)
               report_mismatch("route_ip", got.route_ip, want.route_ip);
            if (got.link_count !== want.link_count)
               report_mismatch("link_count", got.link_count, want.link_count);
            if (got.last !== want.last)
               report_mismatch("last", got.last, want.last);
         end
         rsp_seen++;
      endtask
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;

   link_table_scoreboard sb;
   logic [MAC_W-1:0] key_pool [6];
   bit calm          = 1'b0;
   bit tx_idle_on    = 1'b1;
   bit rsp_idle_on   = 1'b1;
   bit long_hold_req = 1'b0;

   link_address_table #(.TABLE_DEPTH(TABLE_SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #CLK_HALF clock = ~clock;

   function automatic req_word_type req_of(logic [OPCODE_W-1:0] op, logic [MAC_W-1:0] mac,
                                          logic mesh, logic [IP_W-1:0] ip);
      req_word_type w;
      w.opcode   = op;
      w.link_mac = mac;
      w.mesh_in  = mesh;
      w.ip_in    = ip;
      return w;
   endfunction

   // Mostly keyed operations on a small key pool so matches and a full table occur
   function automatic req_word_type random_req(int add_pct);
      int r;
      logic [OPCODE_W-1:0] op;
      logic [MAC_W-1:0] mac;
      logic [IP_W-1:0] ip;
      r = $urandom_range(99);
      if (r < 3) op = OP_CLEAR;
      else if (r < 6) op = OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
      else if (r < 6 + add_pct) op = OP_ADD;
      else begin
         case ($urandom_range(2))
            0: op = OP_REMOVE;
            1: op = OP_SET_IP;
            default: op = OP_QUERY;
         endcase
      end
      if ($urandom_range(6) == 0) mac = MAC_W'({$urandom(), $urandom()});
      else mac = key_pool[$urandom_range(5)];
      ip = ($urandom_range(3) == 0) ? '0 : $urandom();
      return req_of(op, mac, 1'($urandom_range(1)), ip);
   endfunction

   // Offer one word and hold it until accepted; valid stays up for the caller
   task automatic send_word(req_word_type w);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(w);
   endtask

   task automatic send_paced(req_word_type w);
      send_word(w);
      if (tx_idle_on && !calm && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
   endtask

   // Response side: check accepted words and stall in bursts
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD_CYCLES;
         end else if (stall_left == 0 && rsp_idle_on && !calm && $urandom_range(7) == 0) begin
            stall_left = $urandom_range(19, 1);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Request side: reset, directed words, random words, drain
   initial begin : req_side
      int seg;
      sb = new();
      key_pool[0] = MAC_ZERO;
      key_pool[1] = MAC_ONES;
      for (int i = 2; i < 6; i++) key_pool[i] = MAC_W'({$urandom(), $urandom()});
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, duplicates, route drops, spare opcodes, clears
      send_paced(req_of(OP_CLEAR,  MAC_ZERO, 1'b0, '0));
      send_paced(req_of(OP_QUERY,  MAC_ONES, 1'b1, IP_ONES));
      send_paced(req_of(OP_REMOVE, MAC_ZERO, 1'b0, '0));
      send_paced(req_of(OP_SET_IP, MAC_ONES, 1'b0, IP_ONES));
      send_paced(req_of(OP_ADD,    MAC_ZERO, 1'b1, IP_ONES));
      send_paced(req_of(OP_ADD,    MAC_ONES, 1'b1, '0));
      send_paced(req_of(OP_ADD,    MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_QUERY,  MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_SET_IP, MAC_ONES, 1'b0, IP_ONES));
      send_paced(req_of(OP_QUERY,  MAC_ZERO, 1'b0, '0));
      send_paced(req_of(OP_REMOVE, MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_QUERY,  MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_REMOVE, MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_REMOVE, MAC_ONES, 1'b0, '0));
      send_paced(req_of(OP_SET_IP, MAC_ZERO, 1'b0, 32'd1));
      for (int k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
         send_paced(req_of(OPCODE_W'(k), MAC_ONES, 1'b1, IP_ONES));
      send_paced(req_of(OP_ADD,    48'h5555_5555_5555, 1'b0, '0));
      send_paced(req_of(OP_SET_IP, 48'h5555_5555_5555, 1'b0, 32'hA5A5_A5A5));
      send_paced(req_of(OP_CLEAR,  MAC_ONES, 1'b1, IP_ONES));
      send_paced(req_of(OP_CLEAR,  MAC_ZERO, 1'b0, '0));

      // Random: alternate fill-heavy and drain-heavy segments, calm at the end
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         seg = n / SEGMENT_ITEMS;
         calm = (n >= RANDOM_ITEMS - CALM_ITEMS);
         tx_idle_on = (seg % 3) != 1;
         rsp_idle_on = (seg % 3) != 2;
         if (n == LONG_HOLD_ITEM) long_hold_req = 1'b1;
         send_paced(random_req((seg % 2 == 0) ? 70 : 25));
      end
      req_valid <= 1'b0;

      // Drain pending words, then watch for strays
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin : run_limit
      #(RUN_LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/lat_pkg.sv
rtl/core/lat_ram.sv
rtl/core/lat_ctrl.sv
rtl/core/link_address_table.sv
tb/link_address_table_tb.sv
